// ===== hw/rtl/lrs_pkg.sv =====
// lrs_pkg: shared types and constants for the line range selector.
// Used by lrs_parse and line_range_selector; depends on nothing.
`default_nettype none
package lrs_pkg;

  localparam int MAX_RANGES_DEF = 64;

  localparam logic [63:0] U64_MAX   = 64'hFFFF_FFFF_FFFF_FFFF;
  // (U64_MAX - d) / 10 is this for d <= 5, one less for d > 5
  localparam logic [63:0] ACC_LIMIT = 64'd1844674407370955161;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_ONE   = 8'h31;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam logic OP_SPEC  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_INVALID = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;
  localparam logic [1:0] ST_QUERY   = 2'd3;

  typedef enum logic [3:0] {
    PH_IDLE        = 4'd0,
    PH_ITEM        = 4'd1,
    PH_LEAD_DOT    = 4'd2,
    PH_OPEN_WS     = 4'd3,
    PH_END_A       = 4'd4,
    PH_START_NUM   = 4'd5,
    PH_AFTER_START = 4'd6,
    PH_MID_DOT     = 4'd7,
    PH_AFTER_DOTS  = 4'd8,
    PH_END_NUM     = 4'd9,
    PH_AFTER_ITEM  = 4'd10,
    PH_DONE        = 4'd11,
    PH_BAD         = 4'd12,
    PH_FULL        = 4'd13
  } phase_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_FEED0,
    S_INS_RD,
    S_INS_CMP,
    S_EVAL,
    S_MRG_RD,
    S_MRG_CMP,
    S_Q_RD,
    S_Q_CMP,
    S_REPORT
  } state_t;

  typedef struct packed {
    logic        operation;
    logic [7:0]  spec_char;
    logic        spec_last;
    logic [63:0] line_number;
  } in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        wanted;
    logic [63:0] max_line;
    logic        has_max;
  } out_t;

  typedef struct packed {
    logic [63:0] first;
    logic [63:0] last;
  } range_t;

  typedef struct packed {
    logic       feed;
    logic       restart;
    logic       finish;
    logic       tbl_full;
    logic [7:0] ch;
  } prs_ctl_t;

  typedef struct packed {
    phase_t      phase;
    logic        push;
    logic [63:0] push_first;
    logic [63:0] push_last;
  } prs_out_t;

endpackage
`default_nettype wire

// ===== hw/rtl/line_range_selector.sv =====
// line_range_selector: top level; spec parser, sorted range table, merge and queries.
// Depends on lrs_pkg and lrs_parse.
//
// Use: items arrive on the in_ channel (valid/stall). operation 0 carries one spec
// character; spec_last marks the end of a spec, after which one result reports
// status (ok / invalid / full) and, for ok with no open-ended range, the largest range end.
// operation 1 asks about one line number and always gets one result, status 3.
// A spec character with value 0 and no spec_last produces nothing.
// Sequencing: a plain spec character needs no table step. A character that completes
// a range inserts it into the sorted table, reading and shifting up each entry that
// sorts after it. The spec end adds the end-of-text step, then the merge over the
// stored ranges, and then loads the result. A query steps the cursor over the ranges
// that end below the line number. Each table read is registered and has its own
// compare state; in_stall is high meanwhile.
// The result sits in an output register; the next item is accepted while it
// waits. A stalled receiver holds out_data steady; a further result then waits
// in the report state until the register frees up.
// Reset: the table is empty, the parser idle, no result is pending. The table
// memory is not cleared; only entries below the count are ever read.
`default_nettype none
module line_range_selector #(
  parameter int MAX_RANGES = lrs_pkg::MAX_RANGES_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire lrs_pkg::in_t  in_data,
  output logic               out_valid,
  input  wire logic          out_stall,
  output lrs_pkg::out_t      out_data
);

  localparam int AW = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
  localparam int CW = $clog2(MAX_RANGES + 1);

  // range table: one write and one registered read per cycle
  lrs_pkg::range_t mem [MAX_RANGES];
  lrs_pkg::range_t rd_r;
  logic            we, re;
  logic [AW-1:0]   waddr, raddr;
  lrs_pkg::range_t wdata;

  lrs_pkg::prs_ctl_t pctl;
  lrs_pkg::prs_out_t po;

  lrs_pkg::state_t state_r, state_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic [CW-1:0]   cursor_r, cursor_nxt;
  logic [CW-1:0]   r_r, r_nxt;       // merge read pointer
  logic [AW-1:0]   w_r, w_nxt;       // merge write pointer
  logic [AW-1:0]   k_r, k_nxt;       // insert slot
  lrs_pkg::range_t ins_r, ins_nxt;   // range being inserted
  lrs_pkg::range_t cur_r, cur_nxt;   // range being merged
  logic            have_r, have_nxt;
  logic            open_r, open_nxt;
  logic [63:0]     mx_r, mx_nxt;
  logic            last_r, last_nxt;
  logic            fed0_r, fed0_nxt;
  logic [63:0]     line_r, line_nxt;
  lrs_pkg::out_t   res_r, res_nxt;
  logic            out_valid_r, out_valid_nxt;
  lrs_pkg::out_t   out_data_r, out_data_nxt;
  logic            tbl_full;
  lrs_pkg::state_t post_st;

  lrs_parse u_parse (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (pctl),
    .po    (po)
  );

  assign in_stall  = (state_r != lrs_pkg::S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign tbl_full  = (count_r >= CW'(MAX_RANGES));

  always_comb begin
    state_nxt  = state_r;
    count_nxt  = count_r;
    cursor_nxt = cursor_r;
    r_nxt      = r_r;
    w_nxt      = w_r;
    k_nxt      = k_r;
    ins_nxt    = ins_r;
    cur_nxt    = cur_r;
    have_nxt   = have_r;
    open_nxt   = open_r;
    mx_nxt     = mx_r;
    last_nxt   = last_r;
    fed0_nxt   = fed0_r;
    line_nxt   = line_r;
    res_nxt    = res_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && out_stall;
    pctl  = '0;
    we    = 1'b0;
    waddr = '0;
    wdata = ins_r;
    re    = 1'b0;
    raddr = '0;

    // where a spec step goes once its insert (if any) is done
    if (!last_r)      post_st = lrs_pkg::S_IDLE;
    else if (!fed0_r) post_st = lrs_pkg::S_FEED0;
    else              post_st = lrs_pkg::S_EVAL;

    case (state_r)
      lrs_pkg::S_IDLE: begin
        if (in_valid) begin
          if (in_data.operation == lrs_pkg::OP_QUERY) begin
            line_nxt = in_data.line_number;
            res_nxt = '0;
            res_nxt.status = lrs_pkg::ST_QUERY;
            state_nxt = (po.phase == lrs_pkg::PH_DONE) ? lrs_pkg::S_Q_RD
                                                       : lrs_pkg::S_REPORT;
          end else if (in_data.spec_char != lrs_pkg::CH_NUL || in_data.spec_last) begin
            last_nxt = in_data.spec_last;
            fed0_nxt = 1'b0;
            pctl.restart = (po.phase == lrs_pkg::PH_IDLE) ||
                           (po.phase == lrs_pkg::PH_DONE);
            pctl.feed = (in_data.spec_char != lrs_pkg::CH_NUL);
            pctl.ch = in_data.spec_char;
            pctl.tbl_full = pctl.restart ? 1'b0 : tbl_full;
            if (pctl.restart) begin
              count_nxt  = '0;
              cursor_nxt = '0;
            end
            ins_nxt = {po.push_first, po.push_last};
            k_nxt = pctl.restart ? '0 : count_r[AW-1:0];
            if (po.push) state_nxt = lrs_pkg::S_INS_RD;
            else if (!in_data.spec_last) state_nxt = lrs_pkg::S_IDLE;
            else state_nxt = lrs_pkg::S_FEED0;
          end
        end
      end
      lrs_pkg::S_FEED0: begin
        pctl.feed = 1'b1;
        pctl.ch = lrs_pkg::CH_NUL;
        pctl.tbl_full = tbl_full;
        fed0_nxt = 1'b1;
        ins_nxt = {po.push_first, po.push_last};
        k_nxt = count_r[AW-1:0];
        state_nxt = po.push ? lrs_pkg::S_INS_RD : lrs_pkg::S_EVAL;
      end
      lrs_pkg::S_INS_RD: begin
        if (k_r == '0) begin
          we = 1'b1;
          waddr = '0;
          wdata = ins_r;
          count_nxt = count_r + 1'b1;
          state_nxt = post_st;
        end else begin
          re = 1'b1;
          raddr = k_r - 1'b1;
          state_nxt = lrs_pkg::S_INS_CMP;
        end
      end
      lrs_pkg::S_INS_CMP: begin
        we = 1'b1;
        waddr = k_r;
        // shift up while the stored range sorts after the new one
        if (rd_r.first > ins_r.first ||
            (rd_r.first == ins_r.first && rd_r.last > ins_r.last)) begin
          wdata = rd_r;
          k_nxt = k_r - 1'b1;
          state_nxt = lrs_pkg::S_INS_RD;
        end else begin
          wdata = ins_r;
          count_nxt = count_r + 1'b1;
          state_nxt = post_st;
        end
      end
      lrs_pkg::S_EVAL: begin
        pctl.finish = 1'b1;
        res_nxt = '0;
        if (po.phase == lrs_pkg::PH_FULL || po.phase == lrs_pkg::PH_BAD ||
            po.phase != lrs_pkg::PH_AFTER_ITEM || count_r == '0) begin
          res_nxt.status = (po.phase == lrs_pkg::PH_FULL) ? lrs_pkg::ST_FULL
                                                         : lrs_pkg::ST_INVALID;
          count_nxt  = '0;
          cursor_nxt = '0;
          state_nxt  = lrs_pkg::S_REPORT;
        end else begin
          r_nxt    = '0;
          w_nxt    = '0;
          have_nxt = 1'b0;
          open_nxt = 1'b0;
          mx_nxt   = '0;
          state_nxt = lrs_pkg::S_MRG_RD;
        end
      end
      lrs_pkg::S_MRG_RD: begin
        if (r_r < count_r) begin
          re = 1'b1;
          raddr = r_r[AW-1:0];
          state_nxt = lrs_pkg::S_MRG_CMP;
        end else begin
          we = 1'b1;
          waddr = w_r;
          wdata = cur_r;
          count_nxt  = CW'(w_r) + 1'b1;
          cursor_nxt = '0;
          res_nxt.status   = lrs_pkg::ST_OK;
          res_nxt.has_max  = !open_r;
          res_nxt.max_line = open_r ? 64'd0 : mx_r;
          state_nxt = lrs_pkg::S_REPORT;
        end
      end
      lrs_pkg::S_MRG_CMP: begin
        // merged ends are maxima of member ends, so track those directly
        if (rd_r.last == lrs_pkg::U64_MAX) open_nxt = 1'b1;
        if (rd_r.last > mx_r) mx_nxt = rd_r.last;
        if (have_r && (cur_r.last == lrs_pkg::U64_MAX ||
                       rd_r.first <= cur_r.last + 64'd1)) begin
          if (rd_r.last > cur_r.last) cur_nxt.last = rd_r.last;
        end else begin
          if (have_r) begin
            we = 1'b1;
            waddr = w_r;
            wdata = cur_r;
            w_nxt = w_r + 1'b1;
          end
          cur_nxt  = rd_r;
          have_nxt = 1'b1;
        end
        r_nxt = r_r + 1'b1;
        state_nxt = lrs_pkg::S_MRG_RD;
      end
      lrs_pkg::S_Q_RD: begin
        if (cursor_r < count_r) begin
          re = 1'b1;
          raddr = cursor_r[AW-1:0];
          state_nxt = lrs_pkg::S_Q_CMP;
        end else begin
          res_nxt.wanted = 1'b0;
          state_nxt = lrs_pkg::S_REPORT;
        end
      end
      lrs_pkg::S_Q_CMP: begin
        if (line_r < rd_r.first) begin
          res_nxt.wanted = 1'b0;
          state_nxt = lrs_pkg::S_REPORT;
        end else if (line_r <= rd_r.last) begin
          res_nxt.wanted = 1'b1;
          state_nxt = lrs_pkg::S_REPORT;
        end else begin
          cursor_nxt = cursor_r + 1'b1;
          state_nxt = lrs_pkg::S_Q_RD;
        end
      end
      lrs_pkg::S_REPORT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_r;
          state_nxt = lrs_pkg::S_IDLE;
        end
      end
      default: state_nxt = lrs_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rd_r <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lrs_pkg::S_IDLE;
      count_r     <= '0;
      cursor_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      cursor_r    <= cursor_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    r_r        <= r_nxt;
    w_r        <= w_nxt;
    k_r        <= k_nxt;
    ins_r      <= ins_nxt;
    cur_r      <= cur_nxt;
    have_r     <= have_nxt;
    open_r     <= open_nxt;
    mx_r       <= mx_nxt;
    last_r     <= last_nxt;
    fed0_r     <= fed0_nxt;
    line_r     <= line_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(MAX_RANGES))
    else $error("range count above table depth");

  a_cursor_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cursor_r <= count_r)
    else $error("query cursor past range count");

  a_insert_room: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == lrs_pkg::S_INS_RD) |-> (count_r < CW'(MAX_RANGES)))
    else $error("insert into a full table");

  a_query_payload: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.status == lrs_pkg::ST_QUERY) |->
      (!out_data.has_max && out_data.max_line == 64'd0))
    else $error("query answer carries spec fields");

  a_report_new: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == lrs_pkg::S_REPORT && out_valid_r && out_stall) |=> $stable(out_data_r))
    else $error("pending result overwritten");

endmodule
`default_nettype wire

// ===== hw/rtl/lrs_parse.sv =====
// lrs_parse: character-level spec parser; one character per feed cycle.
// Emits range pushes to the table sequencer. Depends on lrs_pkg.
`default_nettype none
module lrs_parse (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire lrs_pkg::prs_ctl_t ctl,
  output lrs_pkg::prs_out_t      po
);

  lrs_pkg::phase_t phase_r, phase_nxt;
  logic [63:0] accum_r, accum_nxt;
  logic [63:0] first_r, first_nxt;

  lrs_pkg::phase_t ph;
  logic [63:0] acc, fst, lim, pa, pb;
  logic [3:0]  dig;
  logic blank, digit, nzdig, bad, psh, ai;

  always_comb begin
    ph    = ctl.restart ? lrs_pkg::PH_ITEM : phase_r;
    acc   = ctl.restart ? 64'd0 : accum_r;
    fst   = ctl.restart ? 64'd0 : first_r;
    dig   = ctl.ch[3:0];
    blank = (ctl.ch == lrs_pkg::CH_SPACE) || (ctl.ch == lrs_pkg::CH_TAB);
    digit = (ctl.ch >= lrs_pkg::CH_ZERO) && (ctl.ch <= lrs_pkg::CH_NINE);
    nzdig = (ctl.ch >= lrs_pkg::CH_ONE) && (ctl.ch <= lrs_pkg::CH_NINE);
    lim   = (dig <= 4'd5) ? lrs_pkg::ACC_LIMIT : lrs_pkg::ACC_LIMIT - 64'd1;
    phase_nxt = ph;
    accum_nxt = acc;
    first_nxt = fst;
    bad = 1'b0;
    psh = 1'b0;
    ai  = 1'b0;
    pa  = fst;
    pb  = fst;
    case (ph)
      lrs_pkg::PH_ITEM: begin
        if (blank) begin
        end else if (ctl.ch == lrs_pkg::CH_DOT) begin
          phase_nxt = lrs_pkg::PH_LEAD_DOT;
        end else if (nzdig) begin
          accum_nxt = {60'd0, dig};
          phase_nxt = lrs_pkg::PH_START_NUM;
        end else begin
          bad = 1'b1;
        end
      end
      lrs_pkg::PH_LEAD_DOT: begin
        if (ctl.ch == lrs_pkg::CH_DOT) phase_nxt = lrs_pkg::PH_OPEN_WS;
        else bad = 1'b1;
      end
      lrs_pkg::PH_OPEN_WS: begin
        if (blank) begin
        end else if (nzdig) begin
          accum_nxt = {60'd0, dig};
          phase_nxt = lrs_pkg::PH_END_A;
        end else begin
          bad = 1'b1;
        end
      end
      lrs_pkg::PH_START_NUM, lrs_pkg::PH_AFTER_START: begin
        if (ph == lrs_pkg::PH_START_NUM && digit) begin
          if (acc > lim) bad = 1'b1;
          else accum_nxt = (acc << 3) + (acc << 1) + {60'd0, dig};
        end else begin
          if (ph == lrs_pkg::PH_START_NUM) first_nxt = acc;
          pa = first_nxt;
          pb = first_nxt;
          if (blank) phase_nxt = lrs_pkg::PH_AFTER_START;
          else if (ctl.ch == lrs_pkg::CH_DOT) phase_nxt = lrs_pkg::PH_MID_DOT;
          else begin
            psh = 1'b1;
            ai  = 1'b1;
          end
        end
      end
      lrs_pkg::PH_MID_DOT: begin
        if (ctl.ch == lrs_pkg::CH_DOT) phase_nxt = lrs_pkg::PH_AFTER_DOTS;
        else begin
          psh = 1'b1;
          bad = 1'b1;
        end
      end
      lrs_pkg::PH_AFTER_DOTS: begin
        if (blank) begin
        end else if (nzdig) begin
          accum_nxt = {60'd0, dig};
          phase_nxt = lrs_pkg::PH_END_NUM;
        end else if (ctl.ch == lrs_pkg::CH_ZERO) begin
          bad = 1'b1;
        end else begin
          pb  = lrs_pkg::U64_MAX;
          psh = 1'b1;
          ai  = 1'b1;
        end
      end
      lrs_pkg::PH_END_A, lrs_pkg::PH_END_NUM: begin
        if (digit) begin
          if (acc > lim) bad = 1'b1;
          else accum_nxt = (acc << 3) + (acc << 1) + {60'd0, dig};
        end else if (ph == lrs_pkg::PH_END_A) begin
          pa  = 64'd1;
          pb  = acc;
          psh = 1'b1;
          ai  = 1'b1;
        end else if (fst > acc) begin
          bad = 1'b1;
        end else begin
          pb  = acc;
          psh = 1'b1;
          ai  = 1'b1;
        end
      end
      lrs_pkg::PH_AFTER_ITEM: ai = 1'b1;
      default: begin
      end
    endcase

    // a push into a full table fails first and hides everything after it
    if (psh && ctl.tbl_full) begin
      phase_nxt = lrs_pkg::PH_FULL;
      psh = 1'b0;
    end else begin
      if (psh) phase_nxt = lrs_pkg::PH_AFTER_ITEM;
      if (ai && !bad) begin
        if (ctl.ch == lrs_pkg::CH_NUL || blank) begin
        end else if (ctl.ch == lrs_pkg::CH_COMMA) phase_nxt = lrs_pkg::PH_ITEM;
        else bad = 1'b1;
      end
      if (bad) phase_nxt = lrs_pkg::PH_BAD;
    end
    if (!ctl.feed) psh = 1'b0;

    po.phase      = phase_r;
    po.push       = psh;
    po.push_first = pa;
    po.push_last  = pb;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= lrs_pkg::PH_IDLE;
    end else if (ctl.finish) begin
      phase_r <= lrs_pkg::PH_DONE;
    end else if (ctl.feed) begin
      phase_r <= phase_nxt;
    end else if (ctl.restart) begin
      phase_r <= lrs_pkg::PH_ITEM;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.feed || ctl.restart) begin
      accum_r <= ctl.feed ? accum_nxt : 64'd0;
      first_r <= ctl.feed ? first_nxt : 64'd0;
    end
  end

endmodule
`default_nettype wire
